// ===== hdl/vrp_pkg.sv =====
package vrp_pkg;

  typedef struct packed {
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic        [15:0] screen_x;
    logic        [15:0] screen_y;
    logic               behind_view;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] cos_ax;
    logic signed [15:0] sin_ax;
    logic signed [15:0] cos_ay;
    logic signed [15:0] sin_ay;
    logic signed [15:0] cos_az;
    logic signed [15:0] sin_az;
    logic        [14:0] field_of_view;
    logic        [15:0] proj_scale;
  } cfg_t;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegCosAx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSinAx = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCosAy = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSinAy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCosAz = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSinAz = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFov   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegScale = 3'd7;

  // Q1.14 pair sum back to Q8.8, round half up, saturate
  function automatic logic signed [15:0] rescale(input logic signed [33:0] sum);
    logic signed [33:0] r;
    r = (sum + 34'sd8192) >>> 14;
    if (r > 34'sd32767) return 16'sh7fff;
    if (r < -34'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

endpackage

// ===== hdl/vrp_rot_stage.sv =====
module vrp_rot_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  input  logic signed [15:0] c_i,
  input  logic signed [15:0] cos_i,
  input  logic signed [15:0] sin_i,
  output logic               valid_o,
  output logic signed [15:0] a_o,
  output logic signed [15:0] b_o,
  output logic signed [15:0] c_o
);
  // a_o = sat(a*cos - b*sin), b_o = sat(a*sin + b*cos), c passes
  logic signed [31:0] ac_q, bs_q, as_q, bc_q;
  logic signed [15:0] c_q;
  logic               v_q, v2_q;
  logic signed [15:0] a2_q, b2_q, c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= valid_i;
      v2_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= a_i * cos_i;
      bs_q <= b_i * sin_i;
      as_q <= a_i * sin_i;
      bc_q <= b_i * cos_i;
      c_q  <= c_i;
      a2_q <= vrp_pkg::rescale(34'(ac_q) - 34'(bs_q));
      b2_q <= vrp_pkg::rescale(34'(as_q) + 34'(bc_q));
      c2_q <= c_q;
    end
  end

  assign valid_o = v2_q;
  assign a_o = a2_q;
  assign b_o = b2_q;
  assign c_o = c2_q;
endmodule

// ===== hdl/vrp_divider.sv =====
module vrp_divider #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [NW-1:0] quo_o,
  output logic          rem_nz_o,
  output logic [TW-1:0] tag_o
);
  // restoring divide, one quotient bit per stage
  logic [NW-1:0] q_q [NW+1];
  logic [DW:0]   r_q [NW+1];
  logic [DW-1:0] d_q [NW+1];
  logic [TW-1:0] t_q [NW+1];

  always_comb begin
    q_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    t_q[0] = tag_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW:0] sh;
    logic        ge;
    assign sh = {r_q[s][DW-1:0], q_q[s][NW-1]};
    assign ge = sh >= {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1] <= ge ? sh - {1'b0, d_q[s]} : sh;
        q_q[s+1] <= {q_q[s][NW-2:0], ge};
        d_q[s+1] <= d_q[s];
        t_q[s+1] <= t_q[s];
      end
    end
  end

  assign quo_o    = q_q[NW];
  assign rem_nz_o = |r_q[NW];
  assign tag_o    = t_q[NW];
endmodule

// ===== hdl/vrp_project.sv =====
module vrp_project #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] z_i,
  input  logic [14:0]       fov_i,
  input  logic [15:0]       scale_i,
  output logic              valid_o,
  output vrp_pkg::out_item_t item_o
);
  localparam int LAT = 48 + 3;
  localparam logic signed [17:0] HalfW = 18'(SCREEN_WIDTH / 2);
  localparam logic signed [17:0] HalfH = 18'(SCREEN_HEIGHT / 2);

  // s1: fov*coord and den
  logic signed [31:0] fx_q, fy_q;
  logic signed [16:0] den_q;
  logic        [15:0] sc_q;
  logic signed [15:0] x1_q, y1_q, z1_q;
  // s2: magnitudes times scale
  logic [46:0] nx_q, ny_q;
  logic        sx_q, sy_q;
  logic [15:0] dd_q;
  logic        bh2_q;
  logic signed [15:0] x2_q, y2_q, z2_q;
  logic [LAT-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[LAT-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q  <= $signed({1'b0, fov_i}) * x_i;
      fy_q  <= $signed({1'b0, fov_i}) * y_i;
      den_q <= $signed({2'b0, fov_i}) + 17'(z_i);
      sc_q  <= scale_i;
      x1_q <= x_i; y1_q <= y_i; z1_q <= z_i;
      sx_q  <= fx_q[31];
      sy_q  <= fy_q[31];
      nx_q  <= 47'(fx_q[31] ? 32'(-fx_q) : 32'(fx_q)) * 47'(sc_q);
      ny_q  <= 47'(fy_q[31] ? 32'(-fy_q) : 32'(fy_q)) * 47'(sc_q);
      bh2_q <= den_q <= 17'sd0;
      dd_q  <= den_q[15:0];
      x2_q <= x1_q; y2_q <= y1_q; z2_q <= z1_q;
    end
  end

  // tag carries sign, behind flag and rotated vertex
  localparam int TW = 3 + 48;
  logic [47:0] qx, qy;
  logic        rx, ry;
  logic [TW-1:0] tx_o, ty_o;

  vrp_divider #(.NW(48), .DW(32), .TW(TW)) u_div_x (
    .clk_i, .en_i,
    .num_i({1'b0, nx_q}), .den_i({dd_q, 16'h0}),
    .tag_i({sx_q, sy_q, bh2_q, x2_q, y2_q, z2_q}),
    .quo_o(qx), .rem_nz_o(rx), .tag_o(tx_o)
  );
  vrp_divider #(.NW(48), .DW(32), .TW(1)) u_div_y (
    .clk_i, .en_i,
    .num_i({1'b0, ny_q}), .den_i({dd_q, 16'h0}),
    .tag_i(1'b0),
    .quo_o(qy), .rem_nz_o(ry), .tag_o(ty_o[0])
  );
  assign ty_o[TW-1:1] = '0;

  function automatic logic [15:0] place(input logic [47:0] q, input logic r,
                                        input logic neg,
                                        input logic signed [17:0] half);
    logic signed [49:0] off;
    logic signed [49:0] v;
    off = neg ? -$signed({2'b0, q}) - 50'(r) : $signed({2'b0, q});
    v = off + 50'(half);
    if (v < 0) return 16'h0;
    if (v > 50'sd65535) return 16'hffff;
    return v[15:0];
  endfunction

  vrp_pkg::out_item_t o_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q.rot_x <= tx_o[47:32];
      o_q.rot_y <= tx_o[31:16];
      o_q.rot_z <= tx_o[15:0];
      o_q.behind_view <= tx_o[48];
      o_q.screen_x <= tx_o[48] ? 16'h0 : place(qx, rx, tx_o[50], HalfW);
      o_q.screen_y <= tx_o[48] ? 16'h0 : place(qy, ry, tx_o[49], HalfH);
    end
  end

  assign valid_o = v_q[LAT-1];
  assign item_o  = o_q;
endmodule

// ===== hdl/vertex_rotate_project.sv =====
// channel  | valid     | stall     | payload
// in       | valid_i   | stall_o   | in_item_i  (vrp_pkg::in_item_t)
// out      | valid_o   | stall_i   | out_item_o (vrp_pkg::out_item_t)
// cfg      | cfg_we_i  | -         | cfg_idx_i, cfg_data_i
// One item per cycle while not stalled: three rotation units of two stages,
// two product stages, a 48-stage restoring divider and one output register.
// Reset clears all valid bits and loads the identity rotation.
// Stall freezes the whole pipeline; stall_o is stall_i while a result waits.
module vertex_rotate_project #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  vrp_pkg::in_item_t  in_item_i,
  output logic               valid_o,
  input  logic               stall_i,
  output vrp_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  vrp_pkg::cfg_t cfg_q;
  logic en, v1, v2, v3;
  logic signed [15:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cos_ax: 16'sd16384, sin_ax: '0, cos_ay: 16'sd16384, sin_ay: '0,
                 cos_az: 16'sd16384, sin_az: '0, field_of_view: 15'd1024,
                 proj_scale: 16'd2560};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vrp_pkg::RegCosAx: cfg_q.cos_ax <= cfg_data_i;
        vrp_pkg::RegSinAx: cfg_q.sin_ax <= cfg_data_i;
        vrp_pkg::RegCosAy: cfg_q.cos_ay <= cfg_data_i;
        vrp_pkg::RegSinAy: cfg_q.sin_ay <= cfg_data_i;
        vrp_pkg::RegCosAz: cfg_q.cos_az <= cfg_data_i;
        vrp_pkg::RegSinAz: cfg_q.sin_az <= cfg_data_i;
        vrp_pkg::RegFov:   cfg_q.field_of_view <= cfg_data_i[14:0];
        vrp_pkg::RegScale: cfg_q.proj_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en = !(valid_o && stall_i);
  assign stall_o = !en;

  // about X: (y,z); about Y: (x,z) with z' = z*c - x*s = -(x*s) + z*c
  vrp_rot_stage u_rx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .a_i(in_item_i.in_y), .b_i(in_item_i.in_z), .c_i(in_item_i.in_x),
    .cos_i(cfg_q.cos_ax), .sin_i(cfg_q.sin_ax),
    .valid_o(v1), .a_o(y1), .b_o(z1), .c_o(x1)
  );
  vrp_rot_stage u_ry (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .a_i(z1), .b_i(x1), .c_i(y1),
    .cos_i(cfg_q.cos_ay), .sin_i(cfg_q.sin_ay),
    .valid_o(v2), .a_o(z2), .b_o(x2), .c_o(y2)
  );
  vrp_rot_stage u_rz (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .a_i(x2), .b_i(y2), .c_i(z2),
    .cos_i(cfg_q.cos_az), .sin_i(cfg_q.sin_az),
    .valid_o(v3), .a_o(x3), .b_o(y3), .c_o(z3)
  );

  vrp_project #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_proj (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3),
    .x_i(x3), .y_i(y3), .z_i(z3),
    .fov_i(cfg_q.field_of_view), .scale_i(cfg_q.proj_scale),
    .valid_o(valid_o), .item_o(out_item_o)
  );

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_item_o))
    else $error("output changed under stall");
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_item_o.behind_view |->
      out_item_o.screen_x == 16'h0 && out_item_o.screen_y == 16'h0)
    else $error("behind item has screen coords");
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without cause");
`endif
endmodule
